[sv/quoted_string_escape_decoder_defines.svh]
// assertion macros used by the bundle queue module (qsed_fifo)
// no dependencies; define NO_ASSERTIONS to leave the checks out
`ifndef QUOTED_STRING_ESCAPE_DECODER_DEFINES_SVH
`define QUOTED_STRING_ESCAPE_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// consequent must hold in the same cycle as the antecedent
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/qsed_pkg.sv]
// shared types and constants of the quoted string escape decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qsed_pkg;

    // queue between the classifier and the output side
    localparam int QUEUE_DEPTH = 4;

    // at most three result words per input byte
    localparam int MAX_RES = 3;
    localparam int RCNT_W  = $clog2(MAX_RES + 1);

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_OPEN  = 3'd1;
    localparam logic [2:0] ST_CLOSE = 3'd2;
    localparam logic [2:0] ST_NULL  = 3'd3;
    localparam logic [2:0] ST_BIG   = 3'd4;

    typedef logic [RCNT_W-1:0] t_rcnt;

    // one result word
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eos;
        logic [2:0] status;
    } t_result;

    // all result words caused by one input byte
    typedef struct packed {
        t_rcnt                 cnt;
        t_result [MAX_RES-1:0] res;
    } t_bundle;

endpackage

`default_nettype wire

[sv/qsed_front.sv]
// classifier: accepts raw bytes, tracks the escape phase, builds result bundles
// depends on qsed_pkg
`timescale 1ns / 1ps
`default_nettype none

module qsed_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic              i_first,
    input  wire logic              i_final_byte,
    output logic                   o_push,
    output qsed_pkg::t_bundle      o_bundle,
    input  wire logic              i_full
);
    import qsed_pkg::*;

    // phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_BODY   = 3'd1;
    localparam logic [2:0] PH_ESC    = 3'd2;
    localparam logic [2:0] PH_ESC_X  = 3'd3;
    localparam logic [2:0] PH_ESC_XH = 3'd4;
    localparam logic [2:0] PH_OCT    = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;

    // hex digit value with a valid flag on top
    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // escaped control letters
    function automatic logic [7:0] f_letter(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h6E: r = 8'd10;
            8'h74: r = 8'd9;
            8'h76: r = 8'd11;
            8'h62: r = 8'd8;
            8'h72: r = 8'd13;
            8'h66: r = 8'd12;
            8'h61: r = 8'd7;
            default: r = c;
        endcase
        return r;
    endfunction

    // append one word to a bundle
    function automatic t_bundle f_emit(input t_bundle b, input logic [7:0] d,
                                       input logic has, input logic [2:0] st);
        t_bundle r;
        r = b;
        if (b.cnt < t_rcnt'(MAX_RES)) begin
            r.res[b.cnt[RCNT_W-1:0]].data   = has ? d : 8'd0;
            r.res[b.cnt[RCNT_W-1:0]].has    = has;
            r.res[b.cnt[RCNT_W-1:0]].eos    = 1'b0;
            r.res[b.cnt[RCNT_W-1:0]].status = st;
            r.cnt = b.cnt + t_rcnt'(1);
        end
        return r;
    endfunction

    // end of string: merge into the last plain byte word, else a word of its own
    function automatic t_bundle f_finish(input t_bundle b, input logic [2:0] st);
        t_bundle r;
        t_rcnt   li;
        r  = b;
        li = b.cnt - t_rcnt'(1);
        if (b.cnt != '0 && b.res[li].has && b.res[li].status == ST_OK && !b.res[li].eos) begin
            r.res[li].eos    = 1'b1;
            r.res[li].status = st;
        end else begin
            r = f_emit(b, 8'd0, 1'b0, st);
            r.res[b.cnt].eos = (b.cnt < t_rcnt'(MAX_RES)) ? 1'b1 : b.res[b.cnt].eos;
        end
        return r;
    endfunction

    // flush an octal escape
    function automatic t_bundle f_flush(input t_bundle b, input logic [8:0] win,
                                        input logic hi);
        t_bundle r;
        if (win[8] || hi) begin
            r = f_emit(b, win[7:0], win[7:0] != 8'd0, ST_BIG);
        end else if (win[7:0] == 8'd0) begin
            r = f_emit(b, 8'd0, 1'b0, ST_NULL);
        end else begin
            r = f_emit(b, win[7:0], 1'b1, ST_OK);
        end
        return r;
    endfunction

    // ordinary text byte
    function automatic t_bundle f_body(input t_bundle b, input logic [7:0] c,
                                       input logic fin);
        t_bundle r;
        r = b;
        if (c == 8'd0) begin
            r = f_finish(b, ST_CLOSE);
        end else if (c == CH_QUOTE) begin
            r = f_finish(b, ST_OK);
        end else if (c == CH_BSLASH) begin
            if (fin) r = f_finish(b, ST_CLOSE);
        end else begin
            r = f_emit(b, c, 1'b1, ST_OK);
            if (fin) r = f_finish(r, ST_CLOSE);
        end
        return r;
    endfunction

    // phase after an ordinary text byte
    function automatic logic [2:0] f_body_phase(input logic [7:0] c, input logic fin);
        logic [2:0] r;
        if (c == 8'd0 || c == CH_QUOTE || fin) begin
            r = PH_DONE;
        end else if (c == CH_BSLASH) begin
            r = PH_ESC;
        end else begin
            r = PH_BODY;
        end
        return r;
    endfunction

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_pend,  n_pend;
    logic [8:0] r_win,   n_win;
    logic       r_hi,    n_hi;

    t_bundle    bnd;
    logic [4:0] hv;
    logic [4:0] hp;
    logic       is_oct;
    logic [8:0] oct_win;
    logic       oct_hi;
    logic       accept;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    // decode of one byte
    always_comb begin
        bnd     = '0;
        n_phase = r_phase;
        n_pend  = r_pend;
        n_win   = r_win;
        n_hi    = r_hi;
        hv      = f_hex(i_in_byte);
        hp      = f_hex(r_pend);
        is_oct  = (i_in_byte[7:3] == 5'b00110);
        oct_win = {r_win[5:0], i_in_byte[2:0]};
        oct_hi  = r_hi || (r_win[8:6] != 3'd0);
        if (i_first) begin
            n_win   = '0;
            n_hi    = 1'b0;
            n_pend  = '0;
            n_phase = PH_BODY;
            if (i_in_byte != CH_QUOTE) bnd = f_emit(bnd, 8'd0, 1'b0, ST_OPEN);
            if (i_final_byte) begin
                bnd     = f_finish(bnd, ST_CLOSE);
                n_phase = PH_DONE;
            end
        end else begin
            case (r_phase)
                PH_BODY: begin
                    bnd     = f_body(bnd, i_in_byte, i_final_byte);
                    n_phase = f_body_phase(i_in_byte, i_final_byte);
                end
                PH_ESC: begin
                    if (i_in_byte == 8'd0) begin
                        bnd     = f_finish(bnd, ST_CLOSE);
                        n_phase = PH_DONE;
                    end else if (i_in_byte == CH_X) begin
                        n_phase = PH_ESC_X;
                        if (i_final_byte) begin
                            bnd     = f_emit(bnd, CH_X, 1'b1, ST_OK);
                            bnd     = f_finish(bnd, ST_CLOSE);
                            n_phase = PH_DONE;
                        end
                    end else if (is_oct) begin
                        n_win   = {6'd0, i_in_byte[2:0]};
                        n_hi    = 1'b0;
                        n_phase = PH_OCT;
                        if (i_final_byte) begin
                            bnd     = f_flush(bnd, {6'd0, i_in_byte[2:0]}, 1'b0);
                            bnd     = f_finish(bnd, ST_CLOSE);
                            n_win   = '0;
                            n_phase = PH_DONE;
                        end
                    end else begin
                        bnd     = f_emit(bnd, f_letter(i_in_byte), 1'b1, ST_OK);
                        n_phase = PH_BODY;
                        if (i_final_byte) begin
                            bnd     = f_finish(bnd, ST_CLOSE);
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_ESC_X: begin
                    if (hv[4]) begin
                        n_pend  = i_in_byte;
                        n_phase = PH_ESC_XH;
                        if (i_final_byte) begin
                            bnd     = f_emit(bnd, CH_X, 1'b1, ST_OK);
                            bnd     = f_emit(bnd, i_in_byte, 1'b1, ST_OK);
                            bnd     = f_finish(bnd, ST_CLOSE);
                            n_phase = PH_DONE;
                        end
                    end else begin
                        bnd     = f_emit(bnd, CH_X, 1'b1, ST_OK);
                        bnd     = f_body(bnd, i_in_byte, i_final_byte);
                        n_phase = f_body_phase(i_in_byte, i_final_byte);
                    end
                end
                PH_ESC_XH: begin
                    if (hv[4]) begin
                        if ({hp[4] ? hp[3:0] : 4'd0, hv[3:0]} == 8'd0) begin
                            bnd = f_emit(bnd, 8'd0, 1'b0, ST_NULL);
                        end else begin
                            bnd = f_emit(bnd, {hp[4] ? hp[3:0] : 4'd0, hv[3:0]}, 1'b1, ST_OK);
                        end
                        n_phase = PH_BODY;
                        if (i_final_byte) begin
                            bnd     = f_finish(bnd, ST_CLOSE);
                            n_phase = PH_DONE;
                        end
                    end else begin
                        bnd     = f_emit(bnd, CH_X, 1'b1, ST_OK);
                        bnd     = f_emit(bnd, r_pend, 1'b1, ST_OK);
                        bnd     = f_body(bnd, i_in_byte, i_final_byte);
                        n_phase = f_body_phase(i_in_byte, i_final_byte);
                    end
                end
                PH_OCT: begin
                    if (is_oct) begin
                        n_win = oct_win;
                        n_hi  = oct_hi;
                        if (i_final_byte) begin
                            bnd     = f_flush(bnd, oct_win, oct_hi);
                            bnd     = f_finish(bnd, ST_CLOSE);
                            n_win   = '0;
                            n_hi    = 1'b0;
                            n_phase = PH_DONE;
                        end
                    end else begin
                        bnd     = f_flush(bnd, r_win, r_hi);
                        n_win   = '0;
                        n_hi    = 1'b0;
                        bnd     = f_body(bnd, i_in_byte, i_final_byte);
                        n_phase = f_body_phase(i_in_byte, i_final_byte);
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    assign o_push   = accept && (bnd.cnt != '0);
    assign o_bundle = bnd;

    // phase and escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pend  <= '0;
            r_win   <= '0;
            r_hi    <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_win   <= n_win;
            r_hi    <= n_hi;
        end
    end

endmodule

`default_nettype wire

[sv/qsed_fifo.sv]
// short queue of result bundles between the classifier and the output side
// depends on qsed_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "quoted_string_escape_decoder_defines.svh"

module qsed_fifo #(
    parameter int DEPTH = qsed_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire qsed_pkg::t_bundle i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output qsed_pkg::t_bundle      o_data,
    output logic                   o_empty
);
    import qsed_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // checks
    `ASSERT_HOLDS(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `ASSERT_HOLDS(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)
    `ASSERT_HOLDS(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CW'(1))

endmodule

`default_nettype wire

[sv/qsed_back.sv]
// output side: walks the words of the head bundle into an output register
// depends on qsed_pkg
`timescale 1ns / 1ps
`default_nettype none

module qsed_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire qsed_pkg::t_bundle i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [7:0]             o_out_byte,
    output logic                   o_has_byte,
    output logic                   o_end_of_string,
    output logic [2:0]             o_status,
    output logic                   o_run_last
);
    import qsed_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    r_last;
    t_rcnt   r_idx;

    logic    load;
    logic    take;
    logic    is_last;

    assign load    = !r_valid || !i_out_stall;
    assign take    = load && !i_empty;
    assign is_last = (r_idx == i_head.cnt - t_rcnt'(1));
    assign o_pop   = take && is_last;

    // word index inside the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_idx <= is_last ? '0 : r_idx + t_rcnt'(1);
            end
            if (load) begin
                r_valid <= !i_empty;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res  <= i_head.res[r_idx];
            r_last <= is_last;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_out_byte      = r_res.data;
    assign o_has_byte      = r_res.has;
    assign o_end_of_string = r_res.eos;
    assign o_status        = r_res.status;
    assign o_run_last      = r_last;

endmodule

`default_nettype wire

[sv/quoted_string_escape_decoder.sv]
// a result word is written into a queue entry at the edge that accepts its byte,
//   then loaded from the queue into the output register
// throughput: one byte per cycle while each byte gives at most one word and the output is not stalled;
//   a byte with more than one word holds the output side until each word is loaded
// the bundle queue (QUEUE_DEPTH deep) lets input run ahead of a stalled output
// synchronous active-low reset clears phase, queue and output valid; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module quoted_string_escape_decoder #(
    parameter int QUEUE_DEPTH = qsed_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_first,
    input  wire logic       i_final_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic            o_end_of_string,
    output logic [2:0]      o_status,
    output logic            o_run_last
);
    import qsed_pkg::*;

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_bundle push_data;
    t_bundle head;

    // classifier
    qsed_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_first      (i_first),
        .i_final_byte (i_final_byte),
        .o_push       (push),
        .o_bundle     (push_data),
        .i_full       (full)
    );

    // bundle queue
    qsed_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head),
        .o_empty (empty)
    );

    // output side
    qsed_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_has_byte      (o_has_byte),
        .o_end_of_string (o_end_of_string),
        .o_status        (o_status),
        .o_run_last      (o_run_last)
    );

endmodule

`default_nettype wire
